[design/sliding_window_min_max_defines.svh]
// Assertion macros for the sliding-window min/max block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SLIDING_WINDOW_MIN_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_DEFINES_SVH

// Antecedent holds in the same cycle as the consequent.
`define SWMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/swmm_pkg.sv]
// Shared types and constants for the sliding-window min/max block.
// No dependencies.
`default_nettype none

package swmm_pkg;

    // Width of the window length register.
    localparam int CFG_W = 7;

    // Per-cell controls driven by the top level.
    typedef struct packed {
        logic shift;    // take the neighbor's sample
        logic advance;  // move the scan wave one cell
        logic active;   // this cell lies inside the window
    } swmm_cell_ctrl_t;

endpackage

`default_nettype wire

[design/swmm_cell.sv]
// One cell of the window chain: holds one sample and one stage of the
// min/max scan wave. Depends on swmm_pkg.
`default_nettype none

module swmm_cell
    import swmm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire swmm_cell_ctrl_t                ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                           wave_vld_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] wave_min_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] wave_max_in,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic                                wave_vld_out,
    output logic signed [SAMPLE_WIDTH-1:0]      wave_min_out,
    output logic signed [SAMPLE_WIDTH-1:0]      wave_max_out
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           wave_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] wave_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] wave_min_next;
    logic signed [SAMPLE_WIDTH-1:0] wave_max_reg;
    logic signed [SAMPLE_WIDTH-1:0] wave_max_next;

    always_comb
    begin
        wave_min_next = wave_min_in;
        wave_max_next = wave_max_in;
        // Fold in the held sample only inside the window; pass through beyond it.
        if (ctrl.active)
        begin
            if (sample_reg < wave_min_in)
            begin
                wave_min_next = sample_reg;
            end
            if (sample_reg > wave_max_in)
            begin
                wave_max_next = sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            sample_reg <= sample_in;
        end
        if (ctrl.advance)
        begin
            wave_min_reg <= wave_min_next;
            wave_max_reg <= wave_max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_vld_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            wave_vld_reg <= wave_vld_in;
        end
    end

    assign sample_out   = sample_reg;
    assign wave_vld_out = wave_vld_reg;
    assign wave_min_out = wave_min_reg;
    assign wave_max_out = wave_max_reg;

endmodule

`default_nettype wire

[design/sliding_window_min_max.sv]
// Sliding-window minimum/maximum over a stream of signed samples: a row of
// WINDOW_MAX cells holds the newest samples, and each accepted item launches a
// scan wave that walks the row one cell per cycle, folding in every cell inside
// the window. A new item is taken only once the previous wave has reached the
// last cell and is not stalled, so the length of the cell row sets the pace; a
// result waiting in the output register does not block the next item, but a
// second result stalls the wave at the last cell until the first is taken.
// No result is given until window_length samples have arrived since the last
// restart; a window_length of 0 acts as 1 and values above WINDOW_MAX act as
// WINDOW_MAX. Depends on swmm_pkg, swmm_cell and the assertion macro header.
`default_nettype none
`include "sliding_window_min_max_defines.svh"

module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_W-1:0]               window_length,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           restart,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      window_min,
    output logic signed [SAMPLE_WIDTH-1:0]      window_max
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int LAST  = WINDOW_MAX - 1;

    logic [CFG_W-1:0]  len_cfg_reg;
    logic [LEN_W-1:0]  len_eff;
    logic [CMP_W-1:0]  len_cfg_ext;
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  fill_next;
    logic              busy_reg;
    logic              launch_reg;
    logic              emit_reg;
    logic              out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_max_reg;
    logic              in_accept;
    logic              wave_done;
    logic              stall;
    logic              advance;

    logic signed [SAMPLE_WIDTH-1:0] sample_chain [0:WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] min_chain    [0:WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] max_chain    [0:WINDOW_MAX];
    logic [WINDOW_MAX:0]            vld_chain;

    // Effective window length: clamp to the range one to WINDOW_MAX.
    always_comb
    begin
        len_cfg_ext = CMP_W'(len_cfg_reg);
        if (len_cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_cfg_ext > CMP_W'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = len_cfg_ext[LEN_W-1:0];
        end
    end

    always_comb
    begin
        if (restart)
        begin
            fill_next = LEN_W'(1);
        end
        else if (fill_reg == LEN_W'(WINDOW_MAX))
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + LEN_W'(1);
        end
    end

    assign wave_done = vld_chain[WINDOW_MAX];
    // Hold the wave at the last cell while a second result has nowhere to go.
    assign stall     = wave_done && emit_reg && out_valid_reg && !out_ready;
    assign advance   = !stall;
    assign in_ready  = !busy_reg || (wave_done && advance);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign sample_chain[0] = sample;
    assign vld_chain[0]    = launch_reg;
    assign min_chain[0]    = sample_chain[1];
    assign max_chain[0]    = sample_chain[1];

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        swmm_cell_ctrl_t cell_ctrl;

        assign cell_ctrl.shift   = in_accept;
        assign cell_ctrl.advance = advance;
        assign cell_ctrl.active  = (LEN_W'(k) < len_eff);

        swmm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .sample_in    (sample_chain[k]),
            .wave_vld_in  (vld_chain[k]),
            .wave_min_in  (min_chain[k]),
            .wave_max_in  (max_chain[k]),
            .sample_out   (sample_chain[k+1]),
            .wave_vld_out (vld_chain[k+1]),
            .wave_min_out (min_chain[k+1]),
            .wave_max_out (max_chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= CFG_W'(1);
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            launch_reg    <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                len_cfg_reg <= window_length;
            end

            if (in_accept)
            begin
                fill_reg   <= fill_next;
                emit_reg   <= (fill_next >= len_eff);
            end

            if (in_accept)
            begin
                launch_reg <= 1'b1;
            end
            else if (advance)
            begin
                launch_reg <= 1'b0;
            end

            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (wave_done && advance)
            begin
                busy_reg <= 1'b0;
            end

            if (wave_done && advance && emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_done && advance && emit_reg)
        begin
            out_min_reg <= min_chain[WINDOW_MAX];
            out_max_reg <= max_chain[WINDOW_MAX];
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_min = out_min_reg;
    assign window_max = out_max_reg;

    `SWMM_ASSERT_SAME(a_one_wave, 1'b1, $onehot0({vld_chain[WINDOW_MAX:1], launch_reg}), "more than one scan wave in flight")
    `SWMM_ASSERT_SAME(a_idle_no_wave, !busy_reg, (vld_chain[WINDOW_MAX:1] == '0) && !launch_reg, "scan wave present while idle")
    `SWMM_ASSERT_NEXT(a_stall_holds, stall, vld_chain[LAST+1], "stalled wave left the last cell")

endmodule

`default_nettype wire

[tb/swmm_window_checker.sv]
`timescale 1ns / 100ps
// Checker for the sliding-window min/max block: watches the config, sample and result channels,
// predicts every window's extremes and compares them with what the block returns.
// Depends on swmm_pkg for the width of the window length register.

module swmm_window_checker
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [CFG_W-1:0]               window_length,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           restart,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] window_min,
    input  logic signed [SAMPLE_WIDTH-1:0] window_max,
    output int unsigned                    mismatches,
    output int unsigned                    pairs_compared,
    output int unsigned                    pairs_pending
);

    localparam int SLOT_W    = $clog2(WINDOW_MAX);
    localparam int MAX_LINES = 40;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] lo;
        logic [SAMPLE_WIDTH-1:0] hi;
    } extremes_t;

    extremes_t                      extremes_due[$];
    logic signed [SAMPLE_WIDTH-1:0] history [WINDOW_MAX];
    int unsigned                    samples_since_restart = 0;
    logic [SLOT_W-1:0]              next_slot = '0;
    logic [CFG_W-1:0]               span_reg = CFG_W'(1);
    int unsigned                    fail_count = 0;
    int unsigned                    compare_count = 0;
    int unsigned                    due_count = 0;

    assign mismatches     = fail_count;
    assign pairs_compared = compare_count;
    assign pairs_pending  = due_count;

    task automatic report_mismatch(input string line);
        fail_count++;
        if (fail_count <= MAX_LINES)
            $display("%0t mismatch: %s", $realtime, line);
    endtask

    // Store the sample, then fold the newest span entries once the window is full.
    task automatic fold_window(input logic signed [SAMPLE_WIDTH-1:0] s, input logic r);
        int unsigned                    span;
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
        logic [SLOT_W-1:0]              idx;
        extremes_t                      e;
        span = (span_reg == 0) ? 1 : ((span_reg > WINDOW_MAX) ? WINDOW_MAX : span_reg);
        if (r)
            samples_since_restart = 0;
        history[next_slot] = s;
        next_slot = next_slot + 1'b1;
        if (samples_since_restart < WINDOW_MAX)
            samples_since_restart++;
        if (samples_since_restart >= span)
        begin
            lo = s;
            hi = s;
            for (int i = 1; i < span; i++)
            begin
                idx = next_slot - SLOT_W'(1 + i);
                if (history[idx] < lo)
                    lo = history[idx];
                if (history[idx] > hi)
                    hi = history[idx];
            end
            e.lo = lo;
            e.hi = hi;
            extremes_due.push_back(e);
        end
    endtask

    task automatic check_result(input logic signed [SAMPLE_WIDTH-1:0] got_lo,
                                input logic signed [SAMPLE_WIDTH-1:0] got_hi);
        extremes_t e;
        if (extremes_due.size() == 0)
        begin
            report_mismatch($sformatf("result min %0d max %0d with no window pending",
                                      got_lo, got_hi));
            return;
        end
        e = extremes_due.pop_front();
        compare_count++;
        if (got_lo !== e.lo)
            report_mismatch($sformatf("window_min %0d, want %0d (result %0d)",
                                      got_lo, $signed(e.lo), compare_count));
        if (got_hi !== e.hi)
            report_mismatch($sformatf("window_max %0d, want %0d (result %0d)",
                                      got_hi, $signed(e.hi), compare_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extremes_due.delete();
            samples_since_restart = 0;
            next_slot = '0;
            span_reg = CFG_W'(1);
            due_count = 0;
        end
        else
        begin
            // Retire the older result before predicting from a newly taken sample.
            if (out_valid && out_ready)
                check_result(window_min, window_max);
            if (cfg_valid && cfg_ready)
                span_reg = window_length;
            if (in_valid && in_ready)
                fold_window(sample, restart);
            due_count = extremes_due.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top of the sliding-window min/max testbench: clock, reset, sample and config stimulus,
// random ready on the result side, and the verdict. Needs swmm_pkg, the block and the checker.

module tb;
    import swmm_pkg::*;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int ITEMS        = 1200;
    localparam int SETTLE       = 2 * (WINDOW_MAX + 1) + 8;
    localparam int LIMIT_CYCLES = 1000000;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_W-1:0]               window_length;
    logic                           in_valid;
    logic                           in_ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           restart;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] window_min;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    int unsigned mismatches;
    int unsigned pairs_compared;
    int unsigned pairs_pending;

    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 47;
    int unsigned samples_sent  = 0;
    int unsigned restarts_sent = 0;
    int unsigned lengths_set   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sliding_window_min_max #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_length(window_length),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_min   (window_min),
        .window_max   (window_max)
    );

    swmm_window_checker #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_min    (window_min),
        .window_max    (window_max),
        .mismatches    (mismatches),
        .pairs_compared(pairs_compared),
        .pairs_pending (pairs_pending)
    );

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
                 pairs_pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = s;
        restart  = r;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        if (r)
            restarts_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pairs_pending != 0)
            @(negedge clk);
    endtask

    // Drain, let a sample that gives no result finish its scan, then write the length.
    task automatic load_window_length(input logic [CFG_W-1:0] len);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_valid     = 1'b1;
        window_length = len;
        do
            @(posedge clk);
        while (!cfg_ready);
        lengths_set++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        logic signed [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(9))
            0: v = S_MAX;
            1: v = S_MIN;
            // dense small values so ties and equal extremes show up
            2, 3: v = $signed(SAMPLE_WIDTH'($urandom_range(16))) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] len_list [13];
        logic [CFG_W-1:0] len;
        int unsigned      span;
        int unsigned      seg_items;
        int unsigned      seg;

        len_list = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd1, 7'd40, 7'd2, 7'd65, 7'd17,
                     7'd100, 7'd3, 7'd63, 7'd8};
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        window_length = '0;
        in_valid      = 1'b0;
        sample        = '0;
        restart       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Length 1 from reset: every sample is its own window.
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample('0, 1'b1);
        push_sample(-1, 1'b0);
        // Zero length acts as one.
        load_window_length('0);
        push_sample(1, 1'b0);
        push_sample(S_MIN, 1'b1);
        // Three-sample window with a restart in the middle of a sequence.
        load_window_length(7'd3);
        push_sample(5, 1'b1);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(7, 1'b1);
        push_sample(8, 1'b0);
        push_sample(9, 1'b0);
        // Shorten the window mid-stream: applies at once.
        load_window_length(7'd2);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MAX, 1'b0);

        seg = 0;
        while (samples_sent < ITEMS)
        begin
            if (samples_sent >= 2 * ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (samples_sent >= ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 26;
            end
            len = (seg % 4 == 3) ? CFG_W'($urandom_range(127)) : len_list[seg % 13];
            seg++;
            load_window_length(len);
            span = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : len);
            seg_items = span + $urandom_range(10, 60);
            // Open most segments with a restart so the window fills from a clean start.
            push_sample(pick_sample(), $urandom_range(3) != 0);
            repeat (seg_items)
            begin
                if ($urandom_range(99) == 0)
                    wait_drained();
                push_sample(pick_sample(), $urandom_range(2 * span + 20) == 0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        $display("%0d samples sent (%0d restarts) under %0d window length writes",
                 samples_sent, restarts_sent, lengths_set);
        $display("%0d min/max results compared, %0d mismatches", pairs_compared, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/swmm_pkg.sv
design/swmm_cell.sv
design/sliding_window_min_max.sv
tb/swmm_window_checker.sv
tb/tb.sv
